@@ sv/assert_macros.svh @@
// Assertion helpers used by the RTL top level. They fall away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Checked on every rising edge outside reset.
`define GDE_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked on every rising edge, reset included.
`define GDE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GDE_ASSERT(lbl, clk, rst_n, prop, msg)
`define GDE_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

@@ sv/gde_pkg.sv @@
package gde_pkg;

  // Field widths.
  localparam int unsigned FREQ_W     = 43;
  localparam int unsigned OFF_W      = 44;
  localparam int unsigned TIME_W     = 44;
  localparam int unsigned TICK_IN_W  = 48;
  localparam int unsigned WIN_W      = 32;
  localparam int unsigned REJ_W      = 8;
  localparam int unsigned ACC_W      = 32;
  localparam int unsigned CFG_W      = 43;
  localparam int unsigned CFG_IDX_W  = 2;

  // GPS time carries 24 fractional bits.
  localparam int unsigned TIME_FRAC_BITS = 24;

  // Parameter defaults.
  localparam int unsigned AVERAGE_SHIFT_DEF      = 4;
  localparam int unsigned TICK_BITS_DEF          = 48;
  localparam int unsigned FREQ_FRACTION_BITS_DEF = 16;

  // Register values after reset.
  localparam logic [FREQ_W-1:0] NOMINAL_CLOCK_RST = 43'd4369062297600;
  localparam logic [WIN_W-1:0]  WIDE_WINDOW_RST   = 32'd218453115;
  localparam logic [WIN_W-1:0]  NARROW_WINDOW_RST = 32'd4369062;
  localparam logic [REJ_W-1:0]  MAX_REJECTS_RST   = 8'd8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NOMINAL_CLOCK = 2'd0,
    CFG_WIDE_WINDOW   = 2'd1,
    CFG_NARROW_WINDOW = 2'd2,
    CFG_MAX_REJECTS   = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_DIV    = 2'd1,
    ST_CHECK  = 2'd2,
    ST_FINISH = 2'd3
  } state_e;

  typedef struct packed {
    logic [TIME_W-1:0]    gps_time;
    logic [TICK_IN_W-1:0] tick_count;
  } in_word_t;

  typedef struct packed {
    logic                     accepted;
    logic                     first_correction;
    logic [FREQ_W-1:0]        raw_estimate;
    logic signed [OFF_W-1:0]  frequency_offset;
    logic [FREQ_W-1:0]        system_clock;
    logic [FREQ_W-1:0]        initial_clock;
    logic signed [OFF_W-1:0]  temperature_offset;
    logic [REJ_W-1:0]         reject_run;
    logic [ACC_W-1:0]         correction_total;
  } out_word_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic step;
    logic check;
    logic finish;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic elapsed_pos;
  } sts_t;

endpackage

@@ sv/gde_datapath.sv @@
module gde_datapath #(
  parameter int unsigned AVERAGE_SHIFT      = gde_pkg::AVERAGE_SHIFT_DEF,
  parameter int unsigned TICK_BITS          = gde_pkg::TICK_BITS_DEF,
  parameter int unsigned FREQ_FRACTION_BITS = gde_pkg::FREQ_FRACTION_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [gde_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [gde_pkg::CFG_W-1:0]         cfg_data_i,
  input  gde_pkg::in_word_t                 in_word_i,
  input  gde_pkg::cmd_t                     cmd_i,
  output gde_pkg::sts_t                     sts_o,
  output gde_pkg::out_word_t                out_word_o
);

  localparam int unsigned FREQ_W = gde_pkg::FREQ_W;
  localparam int unsigned OFF_W  = gde_pkg::OFF_W;
  localparam int unsigned TIME_W = gde_pkg::TIME_W;
  localparam int unsigned WIN_W  = gde_pkg::WIN_W;
  localparam int unsigned REJ_W  = gde_pkg::REJ_W;
  localparam int unsigned ACC_W  = gde_pkg::ACC_W;
  localparam int unsigned SHIFT  = gde_pkg::TIME_FRAC_BITS + FREQ_FRACTION_BITS;
  localparam int unsigned NUM_W  = TICK_BITS + SHIFT;
  localparam int unsigned AVG_W  = FREQ_W + AVERAGE_SHIFT + 1;
  localparam int unsigned WIDE_W = TICK_BITS + gde_pkg::TICK_IN_W;

  // Configuration registers.
  logic [FREQ_W-1:0] nominal_q, nominal_d;
  logic [WIN_W-1:0]  wide_q, wide_d;
  logic [WIN_W-1:0]  narrow_q, narrow_d;
  logic [REJ_W-1:0]  max_rej_q, max_rej_d;

  // Estimator state.
  logic [TICK_BITS-1:0]    prev_ticks_q;
  logic [TIME_W-1:0]       prev_time_q;
  logic [REJ_W-1:0]        rej_q, rej_d;
  logic [ACC_W-1:0]        acc_q, acc_d;
  logic [FREQ_W-1:0]       cur_q, cur_d;
  logic [FREQ_W-1:0]       avg_q, avg_d;
  logic [FREQ_W-1:0]       first_est_q, first_est_d;
  logic signed [OFF_W-1:0] temp_off_q, temp_off_d;

  // Divider and check stage.
  logic [NUM_W-1:0]        num_q;
  logic [TIME_W:0]         rem_q;
  logic [TIME_W-1:0]       den_q;
  logic [FREQ_W-1:0]       quo_q;
  logic                    sat_q;
  logic                    pos_q;
  logic [FREQ_W-1:0]       est_q;
  logic signed [OFF_W-1:0] off_q;
  logic                    ok_q;

  gde_pkg::out_word_t out_q, out_c;

  // Input differences.
  logic [WIDE_W-1:0]    tick_wide;
  logic [TICK_BITS-1:0] tick_ext;
  logic [TICK_BITS-1:0] dticks;
  logic [TIME_W:0]      elapsed;
  logic                 pos_c;

  assign tick_wide = {{TICK_BITS{1'b0}}, in_word_i.tick_count};
  assign tick_ext  = tick_wide[TICK_BITS-1:0];
  assign dticks    = tick_ext - prev_ticks_q;
  assign elapsed   = {1'b0, in_word_i.gps_time} - {1'b0, prev_time_q};
  assign pos_c     = !elapsed[TIME_W] && (elapsed[TIME_W-1:0] != '0);

  // One restoring step per cycle, numerator MSB first.
  logic [TIME_W:0] rem_sh;
  logic [TIME_W:0] den_ext;
  logic            rem_ge;

  assign rem_sh  = {rem_q[TIME_W-1:0], num_q[NUM_W-1]};
  assign den_ext = {1'b0, den_q};
  assign rem_ge  = rem_sh >= den_ext;

  // Window check: |est - cur| <= win, done as two bounds.
  logic [FREQ_W-1:0]       est_c;
  logic [WIN_W-1:0]        win;
  logic [OFF_W-1:0]        win_ext;
  logic [OFF_W-1:0]        est_ext;
  logic [OFF_W-1:0]        cur_ext;
  logic signed [OFF_W-1:0] off_c;
  logic                    ok_c;

  assign est_c   = !pos_q ? '0 : (sat_q ? '1 : quo_q);
  assign win     = ((acc_q == '0) || (rej_q > max_rej_q)) ? wide_q : narrow_q;
  assign win_ext = {{(OFF_W-WIN_W){1'b0}}, win};
  assign est_ext = {1'b0, est_c};
  assign cur_ext = {1'b0, cur_q};
  // Without forward time there is no estimate, so the offset reads as zero.
  assign off_c   = pos_q ? signed'(est_ext - cur_ext) : '0;
  assign ok_c    = pos_q && (est_ext <= cur_ext + win_ext) && (est_ext + win_ext >= cur_ext);

  // Modified moving average: (avg * (2^S - 1) + est) >> S.
  logic [FREQ_W-1:0] avg_use;
  logic [AVG_W-1:0]  avg_sum;
  logic [FREQ_W-1:0] avg_new;
  logic              first_c;

  assign avg_use = (avg_q == '0) ? est_q : avg_q;
  assign avg_sum = {1'b0, avg_use, {AVERAGE_SHIFT{1'b0}}}
                 - {{(AVERAGE_SHIFT+1){1'b0}}, avg_use}
                 + {{(AVERAGE_SHIFT+1){1'b0}}, est_q};
  assign avg_new = avg_sum[AVERAGE_SHIFT+FREQ_W-1:AVERAGE_SHIFT];
  assign first_c = ok_q && (acc_q == '0);

  always_comb begin
    nominal_d   = nominal_q;
    wide_d      = wide_q;
    narrow_d    = narrow_q;
    max_rej_d   = max_rej_q;
    rej_d       = rej_q;
    acc_d       = acc_q;
    cur_d       = cur_q;
    avg_d       = avg_q;
    first_est_d = first_est_q;
    temp_off_d  = temp_off_q;

    if (cfg_we_i) begin
      case (gde_pkg::cfg_idx_e'(cfg_idx_i))
        gde_pkg::CFG_NOMINAL_CLOCK: begin
          nominal_d = cfg_data_i[FREQ_W-1:0];
          if (acc_q == '0) begin
            cur_d       = cfg_data_i[FREQ_W-1:0];
            first_est_d = cfg_data_i[FREQ_W-1:0];
          end
        end
        gde_pkg::CFG_WIDE_WINDOW:   wide_d    = cfg_data_i[WIN_W-1:0];
        gde_pkg::CFG_NARROW_WINDOW: narrow_d  = cfg_data_i[WIN_W-1:0];
        gde_pkg::CFG_MAX_REJECTS:   max_rej_d = cfg_data_i[REJ_W-1:0];
        default: ;
      endcase
    end

    if (cmd_i.finish) begin
      if (ok_q) begin
        rej_d = '0;
        if (acc_q != '1) begin
          acc_d = acc_q + 1'b1;
        end
        avg_d = avg_new;
        cur_d = avg_new;
        if (first_c) begin
          first_est_d = est_q;
          temp_off_d  = off_q;
        end
      end else if (rej_q != '1) begin
        rej_d = rej_q + 1'b1;
      end
    end
  end

  always_comb begin
    out_c.accepted           = ok_q;
    out_c.first_correction   = first_c;
    out_c.raw_estimate       = est_q;
    out_c.frequency_offset   = off_q;
    out_c.system_clock       = cur_d;
    out_c.initial_clock      = first_est_d;
    out_c.temperature_offset = temp_off_d;
    out_c.reject_run         = rej_d;
    out_c.correction_total   = acc_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nominal_q    <= gde_pkg::NOMINAL_CLOCK_RST;
      wide_q       <= gde_pkg::WIDE_WINDOW_RST;
      narrow_q     <= gde_pkg::NARROW_WINDOW_RST;
      max_rej_q    <= gde_pkg::MAX_REJECTS_RST;
      prev_ticks_q <= '0;
      prev_time_q  <= '0;
      rej_q        <= '0;
      acc_q        <= '0;
      cur_q        <= gde_pkg::NOMINAL_CLOCK_RST;
      avg_q        <= '0;
      first_est_q  <= gde_pkg::NOMINAL_CLOCK_RST;
      temp_off_q   <= '0;
      pos_q        <= 1'b0;
    end else begin
      nominal_q   <= nominal_d;
      wide_q      <= wide_d;
      narrow_q    <= narrow_d;
      max_rej_q   <= max_rej_d;
      rej_q       <= rej_d;
      acc_q       <= acc_d;
      cur_q       <= cur_d;
      avg_q       <= avg_d;
      first_est_q <= first_est_d;
      temp_off_q  <= temp_off_d;
      if (cmd_i.load) begin
        prev_ticks_q <= tick_ext;
        prev_time_q  <= in_word_i.gps_time;
        pos_q        <= pos_c;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      num_q <= {dticks, {SHIFT{1'b0}}};
      den_q <= elapsed[TIME_W-1:0];
      rem_q <= '0;
      quo_q <= '0;
      sat_q <= 1'b0;
    end else if (cmd_i.step) begin
      num_q <= {num_q[NUM_W-2:0], 1'b0};
      rem_q <= rem_ge ? (rem_sh - den_ext) : rem_sh;
      // A one shifted out of the top means the quotient exceeds 43 bits.
      sat_q <= sat_q | quo_q[FREQ_W-1];
      quo_q <= {quo_q[FREQ_W-2:0], rem_ge};
    end
    if (cmd_i.check) begin
      est_q <= est_c;
      off_q <= off_c;
      ok_q  <= ok_c;
    end
    if (cmd_i.finish) begin
      out_q <= out_c;
    end
  end

  assign sts_o.elapsed_pos = pos_q;
  assign out_word_o        = out_q;

endmodule

@@ sv/gde_ctrl.sv @@
module gde_ctrl #(
  parameter int unsigned NUM_BITS = gde_pkg::TICK_BITS_DEF + gde_pkg::TIME_FRAC_BITS
                                    + gde_pkg::FREQ_FRACTION_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  gde_pkg::sts_t sts_i,
  output gde_pkg::cmd_t cmd_o
);

  localparam int unsigned CNT_W = $clog2(NUM_BITS);

  gde_pkg::state_e state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;
  logic             div_last;
  logic             slot_free;

  assign div_last  = (cnt_q == CNT_W'(NUM_BITS - 1)) || !sts_i.elapsed_pos;
  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      gde_pkg::ST_IDLE: begin
        cnt_d = '0;
        if (in_valid_i) begin
          state_d = gde_pkg::ST_DIV;
        end
      end
      gde_pkg::ST_DIV: begin
        cnt_d = cnt_q + 1'b1;
        if (div_last) begin
          state_d = gde_pkg::ST_CHECK;
        end
      end
      gde_pkg::ST_CHECK: begin
        state_d = gde_pkg::ST_FINISH;
      end
      gde_pkg::ST_FINISH: begin
        // Hold here until the output register can take the new word.
        if (slot_free) begin
          state_d = gde_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = gde_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      gde_pkg::ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.load   = in_valid_i;
      end
      gde_pkg::ST_DIV: begin
        cmd_o.step   = sts_i.elapsed_pos;
      end
      gde_pkg::ST_CHECK: begin
        cmd_o.check  = 1'b1;
      end
      gde_pkg::ST_FINISH: begin
        cmd_o.finish = slot_free;
        if (slot_free) begin
          out_valid_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= gde_pkg::ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ sv/gps_disciplined_clock_estimator.sv @@
// Frequency estimator disciplined by GPS fixes.
// Each input word carries the GPS time of a fix and the free-running tick count
// sampled at it; each yields exactly one output word with the raw estimate, the
// offset from the system frequency, the averaged system frequency and counters.
// Configuration writes (nominal clock, wide and narrow windows, reject limit) go through
// the plain write port; the user must make them while the block is idle, unchecked.
// Once an input word is accepted, a restoring divider retires its NUM_BITS
// numerator bits one per cycle (NUM_BITS = TICK_BITS + 24 + FREQ_FRACTION_BITS,
// 88 by default); no divide steps run when the elapsed time is zero or negative.
// A check state and a finish state follow; the finish state writes the result.
// A new input word is taken only once the previous result has been written to the
// output register; it may be taken while that result still waits there.
// If the receiver stalls, the finished result waits for the output register to
// free up before it is written.
// Reset clears the counters and history and restores the register defaults;
// the system frequency and initial clock start at the nominal clock.
`include "assert_macros.svh"

module gps_disciplined_clock_estimator #(
  parameter int unsigned AVERAGE_SHIFT      = gde_pkg::AVERAGE_SHIFT_DEF,
  parameter int unsigned TICK_BITS          = gde_pkg::TICK_BITS_DEF,
  parameter int unsigned FREQ_FRACTION_BITS = gde_pkg::FREQ_FRACTION_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [gde_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [gde_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  gde_pkg::in_word_t             in_word_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output gde_pkg::out_word_t            out_word_o
);

  localparam int unsigned NUM_BITS = TICK_BITS + gde_pkg::TIME_FRAC_BITS + FREQ_FRACTION_BITS;

  gde_pkg::cmd_t cmd;
  gde_pkg::sts_t sts;

  gde_ctrl #(
    .NUM_BITS (NUM_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  gde_datapath #(
    .AVERAGE_SHIFT      (AVERAGE_SHIFT),
    .TICK_BITS          (TICK_BITS),
    .FREQ_FRACTION_BITS (FREQ_FRACTION_BITS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_word_i  (in_word_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_word_o (out_word_o)
  );

  `GDE_ASSERT(a_one_cmd, clk_i, rst_ni, $onehot0({cmd.load, cmd.step, cmd.check, cmd.finish}), "more than one datapath command")
  `GDE_ASSERT(a_busy_after_take, clk_i, rst_ni, (in_valid_i && in_ready_o) |=> !in_ready_o, "input taken while a word is in flight")
  `GDE_ASSERT(a_accept_clears_run, clk_i, rst_ni, out_valid_o |-> (!out_word_o.accepted || out_word_o.reject_run == '0), "reject run not cleared on acceptance")
  `GDE_ASSERT(a_first_is_one, clk_i, rst_ni, (out_valid_o && out_word_o.first_correction) |-> (out_word_o.accepted && out_word_o.correction_total == 32'd1), "first correction inconsistent")
  `GDE_ASSERT_ALWAYS(a_reset_idle, clk_i, !rst_ni |-> !out_valid_o, "output valid during reset")

endmodule

@@ tb/tb_gps_disciplined_clock_estimator.sv @@
module tb_gps_disciplined_clock_estimator;
  import gde_pkg::*;

  // Fixed-point scaling between tick counts per GPS time unit and Hz * 65536.
  localparam int unsigned SCALE    = TIME_FRAC_BITS + FREQ_FRACTION_BITS_DEF;
  localparam int unsigned NUM_W    = TICK_IN_W + SCALE;
  localparam longint      FREQ_TOP = (64'sd1 <<< FREQ_W) - 1;
  localparam longint unsigned ONE_SECOND  = 64'd1 << TIME_FRAC_BITS;
  localparam longint unsigned USUAL_TICKS = 64'd66666600;

  class freq_scoreboard;
    logic [FREQ_W-1:0]       nominal_clock;
    logic [WIN_W-1:0]        wide_window;
    logic [WIN_W-1:0]        narrow_window;
    logic [REJ_W-1:0]        max_rejects;
    logic [TICK_IN_W-1:0]    prior_ticks;
    logic [TIME_W-1:0]       prior_time;
    logic [REJ_W-1:0]        reject_run;
    logic [ACC_W-1:0]        correction_total;
    logic [FREQ_W-1:0]       system_clock;
    logic [FREQ_W-1:0]       average;
    logic [FREQ_W-1:0]       initial_clock;
    logic signed [OFF_W-1:0] temp_offset;
    out_word_t               pending[$];
    int unsigned             errors;
    int unsigned             fixes;
    int unsigned             accepts;
    int unsigned             stale_fixes;
    int unsigned             saturated;
    int unsigned             longest_run;

    function new();
      nominal_clock    = NOMINAL_CLOCK_RST;
      wide_window      = WIDE_WINDOW_RST;
      narrow_window    = NARROW_WINDOW_RST;
      max_rejects      = MAX_REJECTS_RST;
      prior_ticks      = '0;
      prior_time       = '0;
      reject_run       = '0;
      correction_total = '0;
      system_clock     = NOMINAL_CLOCK_RST;
      average          = '0;
      initial_clock    = NOMINAL_CLOCK_RST;
      temp_offset      = '0;
      errors           = 0;
      fixes            = 0;
      accepts          = 0;
      stale_fixes      = 0;
      saturated        = 0;
      longest_run      = 0;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [CFG_W-1:0] value);
      case (idx)
        CFG_NOMINAL_CLOCK: begin
          nominal_clock = value[FREQ_W-1:0];
          // The nominal clock only seeds the system frequency until the first correction.
          if (correction_total == '0) begin
            system_clock  = nominal_clock;
            initial_clock = nominal_clock;
          end
        end
        CFG_WIDE_WINDOW:   wide_window   = value[WIN_W-1:0];
        CFG_NARROW_WINDOW: narrow_window = value[WIN_W-1:0];
        CFG_MAX_REJECTS:   max_rejects   = value[REJ_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [WIN_W-1:0] active_window();
      return (correction_total == '0 || reject_run > max_rejects) ? wide_window
                                                                  : narrow_window;
    endfunction

    function void note_fix(in_word_t w);
      logic [TICK_IN_W-1:0] dticks;
      logic [TIME_W-1:0]    elapsed;
      logic [NUM_W-1:0]     quotient;
      logic [FREQ_W-1:0]    estimate;
      longint               offset;
      longint               magnitude;
      longint unsigned      blend;
      bit                   ok;
      bit                   first;
      out_word_t            r;
      dticks   = w.tick_count - prior_ticks;
      elapsed  = w.gps_time - prior_time;
      estimate = '0;
      offset   = 0;
      ok       = 1'b0;
      first    = 1'b0;
      if (w.gps_time > prior_time) begin
        quotient = {dticks, {SCALE{1'b0}}} / {{(NUM_W - TIME_W){1'b0}}, elapsed};
        estimate = (|quotient[NUM_W-1:FREQ_W]) ? {FREQ_W{1'b1}} : quotient[FREQ_W-1:0];
        if (|quotient[NUM_W-1:FREQ_W] || estimate == {FREQ_W{1'b1}}) saturated++;
        offset    = longint'(estimate) - longint'(system_clock);
        magnitude = (offset < 0) ? -offset : offset;
        ok        = magnitude <= longint'(active_window());
      end else begin
        stale_fixes++;
      end
      prior_ticks = w.tick_count;
      prior_time  = w.gps_time;
      if (!ok) begin
        if (reject_run != {REJ_W{1'b1}}) reject_run++;
      end else begin
        first      = (correction_total == '0);
        reject_run = '0;
        if (first) begin
          initial_clock = estimate;
          temp_offset   = OFF_W'(offset);
        end
        // An empty average takes the estimate as its starting point.
        blend        = (average == '0) ? longint'(estimate) : longint'(average);
        blend        = ((blend << AVERAGE_SHIFT_DEF) - blend + estimate) >> AVERAGE_SHIFT_DEF;
        average      = FREQ_W'(blend);
        system_clock = average;
        if (correction_total != {ACC_W{1'b1}}) correction_total++;
        accepts++;
      end
      if (reject_run > longest_run) longest_run = reject_run;
      fixes++;
      r.accepted           = ok;
      r.first_correction   = first;
      r.raw_estimate       = estimate;
      r.frequency_offset   = OFF_W'(offset);
      r.system_clock       = system_clock;
      r.initial_clock      = initial_clock;
      r.temperature_offset = temp_offset;
      r.reject_run         = reject_run;
      r.correction_total   = correction_total;
      pending.push_back(r);
    endfunction

    function void compare(string field, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        if (errors < 10) $display("%s differs: expected %h, got %h", field, want, got);
        errors++;
      end
    endfunction

    function void check_result(out_word_t got);
      out_word_t want;
      if (pending.size() == 0) begin
        if (errors < 10) $display("result word arrived with no fix outstanding: %h", got);
        errors++;
        return;
      end
      want = pending.pop_front();
      compare("accepted", want.accepted, got.accepted);
      compare("first_correction", want.first_correction, got.first_correction);
      compare("raw_estimate", want.raw_estimate, got.raw_estimate);
      compare("frequency_offset", want.frequency_offset, got.frequency_offset);
      compare("system_clock", want.system_clock, got.system_clock);
      compare("initial_clock", want.initial_clock, got.initial_clock);
      compare("temperature_offset", want.temperature_offset, got.temperature_offset);
      compare("reject_run", want.reject_run, got.reject_run);
      compare("correction_total", want.correction_total, got.correction_total);
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst_n;
  logic             cfg_we;
  cfg_idx_e         cfg_idx;
  logic [CFG_W-1:0] cfg_data;
  logic             in_valid;
  logic             in_ready;
  in_word_t         in_word;
  logic             out_valid;
  logic             out_ready = 1'b0;
  out_word_t        out_word;

  int unsigned      src_idle   = 0;
  int unsigned      sink_stall = 0;
  freq_scoreboard   sb;

  gps_disciplined_clock_estimator i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_word_o  (out_word)
  );

  always #5 clk = ~clk;

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= sink_stall);
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) sb.check_result(out_word);
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // A fix that follows the previous one by the given time and tick advance.
  function automatic in_word_t paced_fix(longint unsigned dt, longint unsigned dticks);
    in_word_t w;
    w.gps_time   = sb.prior_time + TIME_W'(dt);
    w.tick_count = sb.prior_ticks + TICK_IN_W'(dticks);
    return w;
  endfunction

  // Half a second to two seconds later, with a tick advance that puts the estimate
  // inside or clearly outside the window that currently applies.
  function automatic in_word_t tracking_fix(bit in_window);
    longint unsigned dt;
    longint unsigned dticks;
    longint          win;
    longint          spread;
    longint          target;
    logic [127:0]    product;
    dt  = $urandom_range(32'd1 << 25, 32'd1 << 23);
    win = longint'(sb.active_window());
    if (in_window) spread = $urandom_range(32'(win - win / 10));
    else spread = win + 131072 + $urandom_range(32'd1 << 20);
    if ($urandom_range(1) == 1) spread = -spread;
    target = longint'(sb.system_clock) + spread;
    if (target < 0) target = 0;
    if (target > FREQ_TOP) target = FREQ_TOP;
    product = 128'(target) * 128'(dt) + (128'd1 << (SCALE - 1));
    dticks  = 64'(product >> SCALE);
    return paced_fix(dt, dticks);
  endfunction

  // No time has passed, or time went backwards.
  function automatic in_word_t stale_fix();
    in_word_t      w;
    logic [63:0]   bits;
    int unsigned   back;
    bits         = rand64();
    back         = $urandom_range(65535);
    w.gps_time   = (sb.prior_time < back) ? '0 : sb.prior_time - back;
    w.tick_count = bits[TICK_IN_W-1:0];
    return w;
  endfunction

  function automatic in_word_t random_fix();
    in_word_t    w;
    logic [63:0] bits;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 78) return tracking_fix(1'b1);
    if (pick < 86) return tracking_fix(1'b0);
    if (pick < 92) return stale_fix();
    bits         = rand64();
    w.gps_time   = bits[TIME_W-1:0];
    bits         = rand64();
    w.tick_count = bits[TICK_IN_W-1:0];
    return w;
  endfunction

  task automatic send_fix(in_word_t w);
    while ($urandom_range(99) < src_idle) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_ready !== 1'b1);
    sb.note_fix(w);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    sb.write_reg(idx, value);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(int unsigned count, int unsigned idle_pct, int unsigned stall_pct,
                           bit stale_only);
    src_idle   = idle_pct;
    sink_stall = stall_pct;
    repeat (count) begin
      // Now and then the sender holds back until every word has come out.
      if ($urandom_range(99) == 0) wait_drained();
      send_fix(stale_only ? stale_fix() : random_fix());
    end
    wait_drained();
  endtask

  initial begin
    #15_000_000;
    $display("[gps_disciplined_clock_estimator] ERROR");
    $finish;
  end

  initial begin
    in_word_t w;
    sb       = new();
    rst_n    = 1'b0;
    cfg_we   = 1'b0;
    cfg_idx  = CFG_NOMINAL_CLOCK;
    cfg_data = '0;
    in_valid = 1'b0;
    in_word  = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Before any correction the nominal clock sets the reference, so try both ends.
    write_reg(CFG_NOMINAL_CLOCK, {CFG_W{1'b1}});
    send_fix(paced_fix(0, 0));
    send_fix(paced_fix(ONE_SECOND, USUAL_TICKS));
    wait_drained();
    write_reg(CFG_NOMINAL_CLOCK, '0);
    send_fix(paced_fix(ONE_SECOND, USUAL_TICKS));
    wait_drained();
    write_reg(CFG_NOMINAL_CLOCK, CFG_W'(NOMINAL_CLOCK_RST));
    send_fix(paced_fix(0, 12345));
    w          = paced_fix(0, 1);
    w.gps_time = sb.prior_time - 5;
    send_fix(w);
    // A huge quotient, one just past the top and one exactly at it.
    send_fix(paced_fix(1, 64'd1 << 47));
    send_fix(paced_fix(64'd1 << SCALE, 64'd1 << FREQ_W));
    send_fix(paced_fix(64'd1 << SCALE, FREQ_TOP));
    repeat (4) send_fix(tracking_fix(1'b1));
    // Over 2^40 time units the estimate equals the tick advance, so the window edges
    // can be hit exactly.
    send_fix(paced_fix(64'd1 << SCALE, sb.system_clock + sb.active_window()));
    send_fix(paced_fix(64'd1 << SCALE, sb.system_clock - sb.active_window() - 1));
    send_fix(paced_fix(64'd1 << SCALE, sb.system_clock - sb.active_window()));
    send_fix(paced_fix(64'd1 << SCALE, sb.system_clock + sb.active_window() + 1));
    w.gps_time   = {TIME_W{1'b1}};
    w.tick_count = {TICK_IN_W{1'b1}};
    send_fix(w);
    w.gps_time   = '0;
    w.tick_count = {TICK_IN_W{1'b1}} - 1000;
    send_fix(w);
    // The tick counter wraps on the next word.
    repeat (3) send_fix(tracking_fix(1'b1));
    wait_drained();

    run_phase(300, 0, 0, 1'b0);
    write_reg(CFG_NARROW_WINDOW, '0);
    write_reg(CFG_WIDE_WINDOW, CFG_W'({WIN_W{1'b1}}));
    write_reg(CFG_MAX_REJECTS, '0);
    run_phase(300, 48, 0, 1'b0);
    write_reg(CFG_NARROW_WINDOW, CFG_W'({WIN_W{1'b1}}));
    write_reg(CFG_WIDE_WINDOW, '0);
    write_reg(CFG_MAX_REJECTS, CFG_W'({REJ_W{1'b1}}));
    run_phase(300, 0, 48, 1'b0);
    // A long run of rejects drives the reject counter into saturation.
    run_phase(270, 35, 35, 1'b1);
    write_reg(CFG_NOMINAL_CLOCK, CFG_W'(NOMINAL_CLOCK_RST));
    write_reg(CFG_WIDE_WINDOW, CFG_W'(WIDE_WINDOW_RST));
    write_reg(CFG_NARROW_WINDOW, CFG_W'(NARROW_WINDOW_RST));
    write_reg(CFG_MAX_REJECTS, CFG_W'(MAX_REJECTS_RST));
    run_phase(500, 35, 35, 1'b0);
    write_reg(CFG_NOMINAL_CLOCK, CFG_W'(rand64()));
    write_reg(CFG_WIDE_WINDOW, CFG_W'($urandom()));
    write_reg(CFG_NARROW_WINDOW, CFG_W'($urandom_range(32'd1 << 26)));
    write_reg(CFG_MAX_REJECTS, CFG_W'($urandom_range(255)));
    run_phase(300, 0, 0, 1'b0);

    repeat (2 * (NUM_W + 3)) @(posedge clk);
    if (sb.pending.size() != 0) begin
      $display("%0d result words never arrived", sb.pending.size());
      sb.errors += sb.pending.size();
    end
    $display("Ran %0d fixes: %0d accepted, %0d without forward time, %0d estimates at the top.",
             sb.fixes, sb.accepts, sb.stale_fixes, sb.saturated);
    $display("Longest reject run %0d; every register was taken to both ends of its range.",
             sb.longest_run);
    if (sb.errors == 0) begin
      $display("[gps_disciplined_clock_estimator] OK");
    end else begin
      $display("[gps_disciplined_clock_estimator] ERROR");
    end
    $finish;
  end

endmodule

@@ gps_disciplined_clock_estimator.f @@
+incdir+sv
sv/gde_pkg.sv
sv/gde_datapath.sv
sv/gde_ctrl.sv
sv/gps_disciplined_clock_estimator.sv
tb/tb_gps_disciplined_clock_estimator.sv
